// ===== rtl/mmcs_pkg.sv =====
// Shared types, constants and helpers for the min/max contrast stretch block.
// Used by every module under rtl; depends on nothing.
package mmcs_pkg;

  localparam int PIX_W       = 16;              // width of a sample field
  localparam int PIXEL_BITS  = 16;              // significant bits of a sample, 8..16
  localparam logic [PIX_W-1:0] FULL_SCALE = PIX_W'((1 << PIXEL_BITS) - 1);
  localparam int NUM_W       = 2 * PIX_W;       // width of (p - min) * FULL_SCALE
  localparam int STEP_W      = $clog2(PIXEL_BITS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int OUT_DATA_W  = 56;              // 50 bits of fields, padded to bytes

  localparam logic RK_STATS   = 1'b0;
  localparam logic RK_STRETCH = 1'b1;

  // One pending result between front and back.
  typedef struct packed {
    logic             kind;      // result kind
    logic [PIX_W-1:0] fmin;      // committed minimum at the time of the item
    logic [PIX_W-1:0] fmax;      // committed maximum
    logic             flat;
    logic             clip;
    logic             div;       // 1: num/den go to the divider
    logic [PIX_W-1:0] num;       // p - min, or the finished value in host order
    logic [PIX_W-1:0] den;       // max - min
  } mmcs_entry_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } mmcs_back_state_t;

  function automatic logic [PIX_W-1:0] swap16(input logic [PIX_W-1:0] w);
    swap16 = {w[7:0], w[15:8]};
  endfunction

endpackage

// ===== rtl/mmcs_front.sv =====
// Front end: takes input transfers, tracks the running and committed range,
// classifies stretch samples and pushes one entry per result. Uses mmcs_pkg.
module mmcs_front import mmcs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [PIX_W-1:0] s_tdata,   // [15:0] pixel_in
  input  logic [0:0]       s_tuser,   // [0] kind
  input  logic             s_tlast,   // last_pixel
  input  logic             q_full,
  output logic             q_push,
  output mmcs_entry_t      q_entry
);

  logic [PIX_W-1:0] running_min, running_max, held_min, held_max;
  logic [PIX_W-1:0] v, new_min, new_max;
  logic             accept, flat, below, above;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign v        = swap16(s_tdata) & FULL_SCALE;
  assign new_min  = (v < running_min) ? v : running_min;
  assign new_max  = (v > running_max) ? v : running_max;
  assign flat     = held_max <= held_min;
  assign below    = v < held_min;
  assign above    = v > held_max;
  assign q_push   = accept && (s_tuser[0] == RK_STRETCH || s_tlast);

  always_comb begin
    if (s_tuser[0] == RK_STATS) begin
      q_entry.kind = RK_STATS;
      q_entry.fmin = new_min;
      q_entry.fmax = new_max;
      q_entry.flat = new_max <= new_min;
      q_entry.clip = 1'b0;
      q_entry.div  = 1'b0;
      q_entry.num  = '0;
      q_entry.den  = '0;
    end else begin
      q_entry.kind = RK_STRETCH;
      q_entry.fmin = held_min;
      q_entry.fmax = held_max;
      q_entry.flat = flat;
      q_entry.clip = !flat && (below || above);
      q_entry.div  = !flat && !below && !above;
      // out-of-range or flat samples carry their final value directly
      q_entry.num  = q_entry.div ? (v - held_min) :
                     (!flat && above) ? FULL_SCALE : '0;
      q_entry.den  = held_max - held_min;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_min <= '1;
      running_max <= '0;
      held_min    <= '0;
      held_max    <= '1;
    end else if (accept && s_tuser[0] == RK_STATS) begin
      if (s_tlast) begin
        held_min    <= new_min;
        held_max    <= new_max;
        running_min <= '1;
        running_max <= '0;
      end else begin
        running_min <= new_min;
        running_max <= new_max;
      end
    end
  end

endmodule

// ===== rtl/mmcs_queue.sv =====
// Short FIFO of pending results between front and back.
// Uses mmcs_pkg for the entry type and depth.
module mmcs_queue import mmcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  mmcs_entry_t wr_entry,
  output logic        full,
  input  logic        pop,
  output mmcs_entry_t rd_entry,
  output logic        empty
);

  mmcs_entry_t          mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]    count;

  assign full     = count == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/mmcs_back.sv =====
// Back end: pops entries, runs the bit-serial restoring divider for in-range
// stretch samples and holds the output register. Uses mmcs_pkg.
module mmcs_back import mmcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  mmcs_entry_t           q_entry,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // [15:0] pixel_out, [31:16] frame_min,
                                          // [47:32] frame_max, [48] flat_frame,
                                          // [49] clipped, [55:50] zero
  output logic [0:0]            m_tuser   // [0] result_kind
);

  mmcs_back_state_t state, state_next;
  mmcs_entry_t      cur;
  logic [PIX_W-1:0] rem, rem_next;
  logic [NUM_W-1:0] sh, num_full;
  logic [PIX_W:0]   trial;
  logic [STEP_W-1:0] cnt;
  logic             load_div, step, load_out, qbit;
  logic [PIX_W-1:0] result;

  // num * FULL_SCALE without a multiplier
  assign num_full = (NUM_W'(q_entry.num) << PIXEL_BITS) - NUM_W'(q_entry.num);
  assign trial    = {rem, sh[NUM_W-1]};
  assign qbit     = trial >= {1'b0, cur.den};
  assign rem_next = qbit ? PIX_W'(trial - {1'b0, cur.den}) : trial[PIX_W-1:0];
  assign result   = cur.div ? sh[PIX_W-1:0] : cur.num;

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_div   = 1'b0;
    step       = 1'b0;
    load_out   = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          load_div   = q_entry.div;
          state_next = q_entry.div ? B_DIV : B_DONE;
        end
      end
      B_DIV: begin
        step = 1'b1;
        if (cnt == STEP_W'(PIXEL_BITS - 1)) state_next = B_DONE;
      end
      B_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_entry;
    if (load_div) begin
      rem <= PIX_W'(num_full >> PIXEL_BITS);
      sh  <= num_full << (NUM_W - PIXEL_BITS);
      cnt <= '0;
    end else if (step) begin
      rem <= rem_next;
      sh  <= {sh[NUM_W-2:0], qbit};
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tuser <= cur.kind;
      m_tdata <= {6'b0, cur.clip, cur.flat, cur.fmax, cur.fmin,
                  (cur.kind == RK_STRETCH) ? swap16(result) : PIX_W'(0)};
    end
  end

endmodule

// ===== rtl/min_max_contrast_stretch.sv =====
// Channel | dir | tdata                                   | tuser        | tlast
// s_*     | in  | [15:0] pixel_in (big-endian)            | [0] kind     | last_pixel
// m_*     | out | pixel_out, frame_min, frame_max,        | [0] result_  | -
//         |     | flat_frame, clipped (see port comments) |     kind     |
//
// Front accepts one transfer per cycle while the 4-entry queue has room.
// Back handles one entry at a time: an in-range stretch sample goes through pop,
// 16 divider steps and output load; statistics, flat and clipped skip the divider.
// Sustained stretch rate is set by the bit-serial divider, one quotient bit a cycle.
// Synchronous reset clears pointers, FSM and output valid and presets the range registers.
// Output stalls back up through the back FSM and the queue to s_tready.
// Top level of the min/max contrast stretch; uses mmcs_pkg and the mmcs_* modules.
module min_max_contrast_stretch import mmcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PIX_W-1:0]      s_tdata,   // [15:0] pixel_in
  input  logic [0:0]            s_tuser,   // [0] kind
  input  logic                  s_tlast,   // last_pixel
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] pixel_out, [31:16] frame_min,
                                           // [47:32] frame_max, [48] flat_frame,
                                           // [49] clipped, [55:50] zero
  output logic [0:0]            m_tuser    // [0] result_kind
);

  mmcs_entry_t push_entry, pop_entry;
  logic        push, pop, full, empty;

  mmcs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_full   (full),
    .q_push   (push),
    .q_entry  (push_entry)
  );

  mmcs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (push_entry),
    .full     (full),
    .pop      (pop),
    .rd_entry (pop_entry),
    .empty    (empty)
  );

  mmcs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (empty),
    .q_entry  (pop_entry),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== rtl/mmcs_checker.sv =====
// Port-level checks for min_max_contrast_stretch, bound to the top level.
// Uses mmcs_pkg for widths and result kinds.
module mmcs_checker import mmcs_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [PIX_W-1:0]      s_tdata,
  input logic [0:0]            s_tuser,
  input logic                  s_tlast,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [0:0]            m_tuser
);

  // stalled result must hold
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // statistics: pixel zero, no clip, flat matches the reported range
  a_stats: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] == RK_STATS |->
      m_tdata[15:0] == '0 && !m_tdata[49] &&
      m_tdata[48] == (m_tdata[47:32] <= m_tdata[31:16]))
    else $error("bad statistics transfer");

  // flat frame stretches everything to zero without clipping
  a_flat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] == RK_STRETCH && m_tdata[48] |->
      m_tdata[15:0] == '0 && !m_tdata[49])
    else $error("flat frame pixel not zero");

  // saturated pixels sit at one end of the scale
  a_clip: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] == RK_STRETCH && m_tdata[49] |->
      m_tdata[15:0] == '0 || m_tdata[15:0] == swap16(FULL_SCALE))
    else $error("clipped pixel not saturated");

endmodule

bind min_max_contrast_stretch mmcs_checker u_mmcs_checker (.*);

// ===== tb/tb_min_max_contrast_stretch.sv =====
// Self-checking testbench for min_max_contrast_stretch: directed table, then random frames.
// Expected: directed table or in-bench predictor; depends on rtl/mmcs_pkg.sv and the RTL.
`timescale 1ns / 100ps
module tb_min_max_contrast_stretch import mmcs_pkg::*; ();

  localparam logic [15:0] PIX_MASK = 16'((32'd1 << PIXEL_BITS) - 1);
  localparam int N_RANDOM_ITEMS = 1200;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;

  // One result as it appears on the master side.
  typedef struct packed {
    logic        rk;
    logic [15:0] pix;
    logic [15:0] fmin;
    logic [15:0] fmax;
    logic        flat;
    logic        clip;
  } stretch_res_t;

  // Directed stimulus row; typed = 1 means the e_* fields hold the expected result.
  typedef struct packed {
    logic        kind;
    logic [15:0] pix;
    logic        last;
    logic        typed;
    logic [15:0] e_pix;
    logic [15:0] e_min;
    logic [15:0] e_max;
    logic        e_flat;
    logic        e_clip;
  } stim_row_t;

  localparam int N_DIRECTED = 24;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // stretch before any measure pass: reset range 0..FFFF maps to itself
    '{1'b1, 16'h0000, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, 1'b0},
    '{1'b1, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 1'b0},
    '{1'b1, 16'h3412, 1'b0, 1'b1, 16'h3412, 16'h0000, 16'hFFFF, 1'b0, 1'b0},
    // measure 1000..8000 (host order)
    '{1'b0, 16'h0010, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0080, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0040, 1'b1, 1'b1, 16'h0000, 16'h1000, 16'h8000, 1'b0, 1'b0},
    // below, at min, at max, above, inside
    '{1'b1, 16'h0008, 1'b0, 1'b1, 16'h0000, 16'h1000, 16'h8000, 1'b0, 1'b1},
    '{1'b1, 16'h0010, 1'b0, 1'b1, 16'h0000, 16'h1000, 16'h8000, 1'b0, 1'b0},
    '{1'b1, 16'h0080, 1'b0, 1'b1, 16'hFFFF, 16'h1000, 16'h8000, 1'b0, 1'b0},
    '{1'b1, 16'h0090, 1'b0, 1'b1, 16'hFFFF, 16'h1000, 16'h8000, 1'b0, 1'b1},
    '{1'b1, 16'h0040, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0},
    '{1'b1, 16'hCD4A, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0},
    // flat frame from a single sample
    '{1'b0, 16'h3412, 1'b1, 1'b1, 16'h0000, 16'h1234, 16'h1234, 1'b1, 1'b0},
    '{1'b1, 16'h3412, 1'b0, 1'b1, 16'h0000, 16'h1234, 16'h1234, 1'b1, 1'b0},
    '{1'b1, 16'hFFFF, 1'b0, 1'b1, 16'h0000, 16'h1234, 16'h1234, 1'b1, 1'b0},
    // full-scale frame
    '{1'b0, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, 1'b0},
    '{1'b1, 16'h00FF, 1'b0, 1'b1, 16'h00FF, 16'h0000, 16'hFFFF, 1'b0, 1'b0},
    // range of a single step
    '{1'b0, 16'h0001, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 16'h0101, 1'b1, 1'b1, 16'h0000, 16'h0100, 16'h0101, 1'b0, 1'b0},
    '{1'b1, 16'h0001, 1'b0, 1'b1, 16'h0000, 16'h0100, 16'h0101, 1'b0, 1'b0},
    '{1'b1, 16'h0101, 1'b0, 1'b1, 16'hFFFF, 16'h0100, 16'h0101, 1'b0, 1'b0},
    '{1'b1, 16'h0000, 1'b0, 1'b1, 16'h0000, 16'h0100, 16'h0101, 1'b0, 1'b1},
    '{1'b1, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 16'h0100, 16'h0101, 1'b0, 1'b1}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;

  // predictor state
  logic [15:0] run_min = 16'hFFFF;
  logic [15:0] run_max = 16'h0000;
  logic [15:0] hold_min = 16'h0000;
  logic [15:0] hold_max = 16'hFFFF;

  stretch_res_t pending_results[$];

  int  errors = 0;
  int  n_items = 0;
  int  n_stats = 0;
  int  n_stretched = 0;
  int  n_clipped = 0;
  int  n_flat = 0;
  int  in_stall_cycles = 0;
  bit  tx_gaps = 1'b0;
  bit  rx_stalls = 1'b0;
  bit  hold_off_go = 1'b0;
  logic hold_off = 1'b0;

  min_max_contrast_stretch dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly zero, some short, a few long.
  function automatic int pick_gap(input bit enable);
    int r;
    r = $urandom_range(0, 99);
    if (!enable || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Updates the frame statistics and returns 1 when the sample yields a result.
  function automatic logic predict_stretch(input logic kind, input logic [15:0] pix,
                                           input logic last, output stretch_res_t r);
    logic [15:0] v;
    logic [31:0] q;
    v = {pix[7:0], pix[15:8]} & PIX_MASK;
    r = '0;
    if (kind == RK_STATS) begin
      if (v < run_min) run_min = v;
      if (v > run_max) run_max = v;
      if (!last) return 1'b0;
      hold_min = run_min;
      hold_max = run_max;
      run_min = 16'hFFFF;
      run_max = 16'h0000;
      r.rk = RK_STATS;
      r.fmin = hold_min;
      r.fmax = hold_max;
      r.flat = (hold_max <= hold_min);
      return 1'b1;
    end
    r.rk = RK_STRETCH;
    r.fmin = hold_min;
    r.fmax = hold_max;
    if (hold_max <= hold_min) begin
      r.flat = 1'b1;
    end else if (v < hold_min) begin
      r.clip = 1'b1;
    end else if (v > hold_max) begin
      r.clip = 1'b1;
      r.pix = {PIX_MASK[7:0], PIX_MASK[15:8]};
    end else begin
      q = (32'(v - hold_min) * 32'(PIX_MASK)) / 32'(hold_max - hold_min);
      if (q > 32'(PIX_MASK)) q = 32'(PIX_MASK);
      r.pix = {q[7:0], q[15:8]};
    end
    return 1'b1;
  endfunction

  // Offers one sample, after an optional gap, and returns once it is transferred.
  task automatic send_pixel(input logic kind, input logic [15:0] pix, input logic last);
    int gap;
    gap = pick_gap(tx_gaps);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= pix;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    n_items++;
  endtask

  task automatic drive_sample(input logic kind, input logic [15:0] pix, input logic last);
    stretch_res_t r;
    send_pixel(kind, pix, last);
    if (predict_stretch(kind, pix, last, r)) pending_results.push_back(r);
  endtask

  // Measure pass over a random range, then a stretch pass mostly inside it.
  task automatic random_frame();
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] v;
    int span;
    int n_meas;
    int n_str;
    int style;
    style = $urandom_range(0, 9);
    lo = 16'($urandom);
    if (style == 0) span = 0;
    else if (style < 3) span = 65535;
    else if (style < 6) span = $urandom_range(1, 15);
    else span = $urandom_range(16, 65535);
    hi = (32'(lo) + span > 65535) ? 16'hFFFF : 16'(32'(lo) + span);
    if (style == 1 || style == 2) lo = 16'h0000;
    n_meas = $urandom_range(1, 8);
    for (int i = 0; i < n_meas; i++) begin
      v = 16'($urandom_range(lo, hi));
      drive_sample(RK_STATS, {v[7:0], v[15:8]}, i == n_meas - 1);
    end
    n_str = $urandom_range(1, 20);
    for (int i = 0; i < n_str; i++) begin
      if ($urandom_range(0, 9) < 7) v = 16'($urandom_range(lo, hi));
      else v = 16'($urandom);
      drive_sample(RK_STRETCH, {v[7:0], v[15:8]}, 1'($urandom));
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function automatic void check_result();
    stretch_res_t e;
    if (pending_results.size() == 0) begin
      $error("result with nothing expected: tuser %h tdata %h", m_tuser, m_tdata);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    check_field("result_kind", 16'(e.rk), 16'(m_tuser[0]));
    check_field("pixel_out", e.pix, m_tdata[15:0]);
    check_field("frame_min", e.fmin, m_tdata[31:16]);
    check_field("frame_max", e.fmax, m_tdata[47:32]);
    check_field("flat_frame", 16'(e.flat), 16'(m_tdata[48]));
    check_field("clipped", 16'(e.clip), 16'(m_tdata[49]));
    check_field("tdata_pad", 16'h0000, 16'(m_tdata[55:50]));
    if (e.rk == RK_STATS) n_stats++;
    else n_stretched++;
    if (e.clip) n_clipped++;
    if (e.flat) n_flat++;
  endfunction

  // Receiver: checks each transfer, counts input stalls and decides tready for the next cycle.
  initial begin
    int rx_wait;
    rx_wait = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) check_result();
      if (!rst && s_tvalid && !s_tready) in_stall_cycles++;
      if (hold_off) begin
        m_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        rx_wait = pick_gap(1'b1);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off so the queue fills and input backpressure kicks in.
  initial begin
    wait (hold_off_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    stretch_res_t r;
    stretch_res_t typed_r;
    stim_row_t row;
    int n_pressure;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      send_pixel(row.kind, row.pix, row.last);
      if (predict_stretch(row.kind, row.pix, row.last, r)) begin
        if (row.typed) begin
          typed_r = '{row.kind, row.e_pix, row.e_min, row.e_max, row.e_flat, row.e_clip};
          pending_results.push_back(typed_r);
        end else begin
          pending_results.push_back(r);
        end
      end
    end

    n_pressure = 0;
    while (n_items < N_DIRECTED + N_RANDOM_ITEMS) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      if (!hold_off_go && n_items > 400) begin
        // back-to-back transfers while the receiver holds off
        hold_off_go = 1'b1;
        tx_gaps = 1'b0;
        for (n_pressure = 0; n_pressure < 40; n_pressure++) random_frame();
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4))
          drive_sample(1'($urandom), 16'($urandom), 1'($urandom));
      end else begin
        random_frame();
      end
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d samples: %0d statistics and %0d stretched results,",
             n_items, n_stats, n_stretched);
    $display("%0d clipped, %0d flat, %0d cycles of input backpressure.",
             n_clipped, n_flat, in_stall_cycles);
    if (errors == 0) begin
      $display("tb_min_max_contrast_stretch: PASS");
    end else begin
      $display("tb_min_max_contrast_stretch: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected", pending_results.size());
    $display("tb_min_max_contrast_stretch: FAIL");
    $finish;
  end

endmodule
